// ===== src/oifr_pkg.sv =====
// Package for the optical index frame receiver.
// Holds frame geometry constants, codes and the classifier result type.
// No dependencies; imported by every module of the block.
package oifr_pkg;

  // Frame geometry.
  localparam int SHORT_TAIL_BITS = 16;
  localparam int LONG_DATA_BITS  = 32;
  localparam int HDR_BITS        = 7;
  localparam int LONG_SKIP_BITS  = 6;

  localparam int SHORT_WORD_BITS = HDR_BITS + SHORT_TAIL_BITS;
  localparam int SKIP_END        = HDR_BITS + LONG_SKIP_BITS;
  localparam int LONG_END        = SKIP_END + LONG_DATA_BITS;
  localparam int CNT_W           = $clog2(LONG_END + 1);

  localparam logic [HDR_BITS-1:0] LONG_HDR = HDR_BITS'(7'h61);

  localparam logic [31:0] SHORT_MASK = 32'((64'd1 << SHORT_WORD_BITS) - 64'd1);
  localparam logic [31:0] LONG_MASK  = 32'((64'd1 << LONG_DATA_BITS) - 64'd1);

  // Short word bit positions.
  localparam int PRESENT_BIT = 22;
  localparam int NOCODE_BIT  = 21;
  localparam int IDX_W       = 18;
  localparam int GROUP_LSB   = 18;

  // Register and field widths.
  localparam int CODE_W      = 23;
  localparam int TIMER_W     = 16;
  localparam int INDEX_OUT_W = 16;
  localparam int CFG_WDATA_W = 23;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POWER_DOWN_CODE   = 3'd0,
    CFG_SYSTEM_RESET_CODE = 3'd1,
    CFG_DONT_CARE_INDEX   = 3'd2,
    CFG_MISSING_MIN       = 3'd3,
    CFG_MISSING_MAX       = 3'd4,
    CFG_HOLD_MS           = 3'd5,
    CFG_RELEASE_MS        = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_BIT   = 2'd1,
    FUNC_TICK  = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_VALID      = 3'd0,
    ST_NO_INDEX   = 3'd1,
    ST_IGNORED    = 3'd2,
    ST_POWER_DOWN = 3'd3,
    ST_SYS_RESET  = 3'd4,
    ST_TIMEOUT    = 3'd5
  } status_t;

  // Decision for a completed frame.
  typedef struct packed {
    status_t status;
    logic    take_index;   // valid index: pen on, timer reload
    logic    release_pen;  // pen off, pen leave set
    logic    power_down;   // timer stopped, index cleared
  } cls_t;

endpackage

// ===== src/oifr_classify.sv =====
// Classification of a completed frame word for the optical index frame receiver.
// Pure combinational decode against the configured codes and index range.
// Depends on oifr_pkg.
module oifr_classify (
  input  logic [31:0]                    word,
  input  logic                           long_frame,
  input  logic [oifr_pkg::CODE_W-1:0]    power_down_code,
  input  logic [oifr_pkg::CODE_W-1:0]    system_reset_code,
  input  logic [oifr_pkg::IDX_W-1:0]     dont_care_index,
  input  logic [oifr_pkg::IDX_W-1:0]     missing_min,
  input  logic [oifr_pkg::IDX_W-1:0]     missing_max,
  output oifr_pkg::cls_t                 cls
);
  import oifr_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             is_sys_reset;
  logic             is_power_down;
  logic             no_code;
  logic             in_missing;

  assign idx           = word[IDX_W-1:0];
  assign is_sys_reset  = (word == 32'(system_reset_code));
  assign is_power_down = (word == 32'(power_down_code));
  assign no_code       = !word[PRESENT_BIT] || word[NOCODE_BIT];
  // An empty range (min above max) never matches.
  assign in_missing    = (idx >= missing_min) && (idx <= missing_max);

  always_comb begin
    cls = '{status: ST_VALID, take_index: 1'b1, release_pen: 1'b0, power_down: 1'b0};
    if (long_frame) begin
      cls = '{status: ST_VALID, take_index: 1'b1, release_pen: 1'b0, power_down: 1'b0};
    end else if (is_sys_reset) begin
      cls = '{status: ST_SYS_RESET, take_index: 1'b0, release_pen: 1'b0, power_down: 1'b0};
    end else if (is_power_down) begin
      cls = '{status: ST_POWER_DOWN, take_index: 1'b0, release_pen: 1'b1, power_down: 1'b1};
    end else if (no_code) begin
      cls = '{status: ST_NO_INDEX, take_index: 1'b0, release_pen: 1'b1, power_down: 1'b0};
    end else if (idx == dont_care_index) begin
      cls = '{status: ST_IGNORED, take_index: 1'b0, release_pen: 1'b0, power_down: 1'b0};
    end else if (in_missing) begin
      cls = '{status: ST_NO_INDEX, take_index: 1'b0, release_pen: 1'b1, power_down: 1'b0};
    end
  end

endmodule

// ===== src/optical_index_frame_receiver.sv =====
// Top level of the optical index frame receiver.
// Holds the frame shifter, pen state, hold timer and result register.
// Depends on oifr_pkg and oifr_classify.
//
// Usage:
//   The input channel carries one event per beat: a frame start, one sampled
//   data line bit, or a one millisecond tick. Events are applied to the frame
//   and pen state in the cycle they are accepted, so one beat per cycle is
//   sustained while not stalled. A beat that completes a frame, or a tick
//   that ends the hold time, produces one result beat; all other beats
//   produce none. The result appears on the output channel in the cycle
//   after the input beat is accepted and stays until the receiver takes it.
//   The single output register sets throughput: input stall is raised only
//   while a result is waiting and the output is stalled. When the output is
//   free or being taken in the same cycle, a new input beat is accepted.
//   Configuration writes take effect on the next clock edge and should be
//   made while no frame is in progress.
//   A synchronous reset (rst_n low) clears the frame, the timer (inactive),
//   pen_on, index and ready flag, sets pen_leave, loads the default hold and
//   release times and empties the output register.
module optical_index_frame_receiver (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_func,
  input  logic                                in_sdio_bit,
  input  logic                                in_flag_enable,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_status,
  output logic                                out_long_format,
  output logic [31:0]                         out_raw_word,
  output logic [15:0]                         out_index_value,
  output logic [1:0]                          out_code_group,
  output logic                                out_pen_on,
  output logic                                out_pen_leave,
  output logic                                out_index_ready,
  input  logic                                cfg_wr_en,
  input  logic [oifr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [oifr_pkg::CFG_WDATA_W-1:0]    cfg_wdata
);
  import oifr_pkg::*;

  // Configuration.
  logic [CODE_W-1:0]  power_down_code_r;
  logic [CODE_W-1:0]  system_reset_code_r;
  logic [IDX_W-1:0]   dont_care_index_r;
  logic [IDX_W-1:0]   missing_min_r;
  logic [IDX_W-1:0]   missing_max_r;
  logic [TIMER_W-1:0] hold_ms_r;
  logic [TIMER_W-1:0] release_ms_r;

  // Frame and pen state.
  logic [HDR_BITS-1:0]    header_r, header_nxt;
  logic [31:0]            data_r, data_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   long_r, long_nxt;
  logic                   active_r, active_nxt;
  logic [TIMER_W-1:0]     timer_r, timer_nxt;
  logic                   pen_on_r, pen_on_nxt;
  logic                   pen_leave_r, pen_leave_nxt;
  logic [INDEX_OUT_W-1:0] index_r, index_nxt;
  logic                   ready_r, ready_nxt;

  // Result register.
  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r;
  logic                   out_long_r;
  logic [31:0]            out_raw_r;
  logic [INDEX_OUT_W-1:0] out_index_r;
  logic [1:0]             out_group_r;
  logic                   out_pen_on_r;
  logic                   out_pen_leave_r;
  logic                   out_ready_r;

  // Per-beat working signals.
  logic                   in_accept;
  logic                   res_valid;
  status_t                res_status;
  logic [31:0]            res_raw;
  logic [1:0]             res_group;
  logic                   finish;
  logic [CNT_W-1:0]       count_inc;
  logic [HDR_BITS-1:0]    header_shift;
  logic [TIMER_W-1:0]     timer_dec;
  cls_t                   cls;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign count_inc    = count_r + CNT_W'(1);
  assign header_shift = {header_r[HDR_BITS-2:0], in_sdio_bit};
  assign timer_dec    = timer_r - TIMER_W'(1);

  oifr_classify u_classify (
    .word              (data_nxt),
    .long_frame        (long_r),
    .power_down_code   (power_down_code_r),
    .system_reset_code (system_reset_code_r),
    .dont_care_index   (dont_care_index_r),
    .missing_min       (missing_min_r),
    .missing_max       (missing_max_r),
    .cls               (cls)
  );

  always_comb begin
    header_nxt    = header_r;
    data_nxt      = data_r;
    count_nxt     = count_r;
    long_nxt      = long_r;
    active_nxt    = active_r;
    timer_nxt     = timer_r;
    pen_on_nxt    = pen_on_r;
    pen_leave_nxt = pen_leave_r;
    index_nxt     = index_r;
    ready_nxt     = ready_r;
    res_valid     = 1'b0;
    res_status    = ST_VALID;
    res_raw       = '0;
    res_group     = '0;
    finish        = 1'b0;

    if (in_accept) begin
      case (func_t'(in_func))
        FUNC_START: begin
          header_nxt = '0;
          data_nxt   = '0;
          count_nxt  = '0;
          long_nxt   = 1'b0;
          active_nxt = 1'b1;
        end
        FUNC_TICK: begin
          if (timer_r != '0) begin
            timer_nxt = timer_dec;
            if (timer_dec == '0) begin
              timer_nxt     = release_ms_r;
              pen_on_nxt    = 1'b0;
              pen_leave_nxt = 1'b1;
              res_valid     = 1'b1;
              res_status    = ST_TIMEOUT;
            end
          end
        end
        FUNC_BIT: begin
          if (active_r) begin
            count_nxt = count_inc;
            if (count_r < CNT_W'(HDR_BITS)) begin
              header_nxt = header_shift;
              if (count_inc == CNT_W'(HDR_BITS)) begin
                if (header_shift == LONG_HDR) begin
                  long_nxt = 1'b1;
                end else begin
                  data_nxt = 32'(header_shift);
                end
              end
            end else if (!long_r) begin
              data_nxt = {data_r[30:0], in_sdio_bit} & SHORT_MASK;
              finish   = (count_inc >= CNT_W'(SHORT_WORD_BITS));
            end else if (count_r >= CNT_W'(SKIP_END)) begin
              // Past the discarded header bits of a long frame.
              data_nxt = {data_r[30:0], in_sdio_bit} & LONG_MASK;
              finish   = (count_inc >= CNT_W'(LONG_END));
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (finish) begin
      active_nxt = 1'b0;
      res_valid  = 1'b1;
      res_status = cls.status;
      res_raw    = data_nxt;
      res_group  = long_r ? 2'b00 : data_nxt[GROUP_LSB+1:GROUP_LSB];
      if (cls.take_index) begin
        pen_on_nxt = 1'b1;
        timer_nxt  = hold_ms_r;
        index_nxt  = data_nxt[INDEX_OUT_W-1:0];
        if (in_flag_enable) begin
          ready_nxt = 1'b1;
        end
      end
      if (cls.release_pen) begin
        pen_on_nxt    = 1'b0;
        pen_leave_nxt = 1'b1;
      end
      if (cls.power_down) begin
        timer_nxt = '0;
        index_nxt = '0;
      end
    end

    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_down_code_r   <= '0;
      system_reset_code_r <= '0;
      dont_care_index_r   <= '0;
      missing_min_r       <= '0;
      missing_max_r       <= '0;
      hold_ms_r           <= TIMER_W'(1000);
      release_ms_r        <= TIMER_W'(100);
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_POWER_DOWN_CODE:   power_down_code_r   <= cfg_wdata[CODE_W-1:0];
        CFG_SYSTEM_RESET_CODE: system_reset_code_r <= cfg_wdata[CODE_W-1:0];
        CFG_DONT_CARE_INDEX:   dont_care_index_r   <= cfg_wdata[IDX_W-1:0];
        CFG_MISSING_MIN:       missing_min_r       <= cfg_wdata[IDX_W-1:0];
        CFG_MISSING_MAX:       missing_max_r       <= cfg_wdata[IDX_W-1:0];
        CFG_HOLD_MS:           hold_ms_r           <= cfg_wdata[TIMER_W-1:0];
        CFG_RELEASE_MS:        release_ms_r        <= cfg_wdata[TIMER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r    <= '0;
      data_r      <= '0;
      count_r     <= '0;
      long_r      <= 1'b0;
      active_r    <= 1'b0;
      timer_r     <= '0;
      pen_on_r    <= 1'b0;
      pen_leave_r <= 1'b1;
      index_r     <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      header_r    <= header_nxt;
      data_r      <= data_nxt;
      count_r     <= count_nxt;
      long_r      <= long_nxt;
      active_r    <= active_nxt;
      timer_r     <= timer_nxt;
      pen_on_r    <= pen_on_nxt;
      pen_leave_r <= pen_leave_nxt;
      index_r     <= index_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload loads only with a new result.
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_status_r    <= res_status;
      out_long_r      <= long_nxt;
      out_raw_r       <= res_raw;
      out_index_r     <= index_nxt;
      out_group_r     <= res_group;
      out_pen_on_r    <= pen_on_nxt;
      out_pen_leave_r <= pen_leave_nxt;
      out_ready_r     <= ready_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_long_format = out_long_r;
  assign out_raw_word    = out_raw_r;
  assign out_index_value = out_index_r;
  assign out_code_group  = out_group_r;
  assign out_pen_on      = out_pen_on_r;
  assign out_pen_leave   = out_pen_leave_r;
  assign out_index_ready = out_ready_r;

endmodule

// ===== src/oifr_checker.sv =====
// Port-level checker for the optical index frame receiver.
// Watches only the top-level ports; bound to the top level below.
// Depends on oifr_pkg.
module oifr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [31:0] out_raw_word,
  input logic [15:0] out_index_value,
  input logic [1:0]  out_code_group,
  input logic        out_pen_on,
  input logic        out_pen_leave
);
  import oifr_pkg::*;

  // The output register is empty right after reset.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // Input stall only comes from a waiting, stalled result.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // A stalled result beat holds its payload.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_status) && $stable(out_raw_word)
       && $stable(out_index_value)))
    else $error("stalled result beat changed");

  // A valid index always leaves the pen on.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_VALID)) |-> out_pen_on)
    else $error("valid index result without pen on");

  // A timeout releases the pen and carries no word.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_TIMEOUT)) |->
      (!out_pen_on && out_pen_leave && (out_raw_word == 32'd0)
       && (out_code_group == 2'd0)))
    else $error("timeout result with inconsistent pen state");

endmodule

bind optical_index_frame_receiver oifr_checker u_oifr_checker (.*);

// ===== tb/optical_index_frame_receiver_tb.sv =====
// Self-checking testbench for optical_index_frame_receiver.
// Drives sensor events through the input channel and scores each result beat against a
// built-in frame decoder. Depends on oifr_pkg and the RTL of the block only.
module optical_index_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import oifr_pkg::*;

  localparam logic [1:0] FUNC_UNUSED   = 2'd3;
  localparam int         MAX_SHOWN     = 10;
  localparam int         DRAIN_LIMIT   = 5000;
  localparam int         SETTLE_CYCLES = 6;
  localparam int         PHASE_BEATS   = 55;
  localparam int         RANDOM_PHASES = 8;
  localparam int         RUN_LIMIT_NS  = 5_000_000;

  typedef struct packed {
    logic [1:0] func;
    logic       sdio;
    logic       flag_en;
  } sensor_beat_t;

  typedef struct packed {
    status_t     status;
    logic        long_fmt;
    logic [31:0] raw;
    logic [15:0] index;
    logic [1:0]  group;
    logic        pen_on;
    logic        pen_leave;
    logic        ready;
  } index_report_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             in_func = FUNC_START;
  logic                   in_sdio_bit = 1'b0;
  logic                   in_flag_enable = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [2:0]             out_status;
  logic                   out_long_format;
  logic [31:0]            out_raw_word;
  logic [15:0]            out_index_value;
  logic [1:0]             out_code_group;
  logic                   out_pen_on;
  logic                   out_pen_leave;
  logic                   out_index_ready;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = CFG_POWER_DOWN_CODE;
  logic [CFG_WDATA_W-1:0] cfg_wdata = '0;

  sensor_beat_t  beat_queue[$];
  index_report_t report_queue[$];

  // Decoder state, mirrored from the block.
  logic [HDR_BITS-1:0] m_hdr;
  logic [31:0]         m_shift;
  int                  m_nbits;
  logic                m_long, m_in_frame;
  logic [15:0]         m_hold, m_index;
  logic                m_pen_on, m_pen_leave, m_ready;

  // Register shadow.
  logic [CODE_W-1:0]  c_pd, c_sr;
  logic [IDX_W-1:0]   c_dc, c_lo, c_hi;
  logic [TIMER_W-1:0] c_hold, c_rel;

  int failures = 0;
  int beats_queued = 0;
  int beats_taken = 0;
  int results_seen = 0;
  int settings_loaded = 1;
  int send_gap = 0, send_calm = 0;
  int stall_left = 0, recv_calm = 0;
  int status_hits[6] = '{default: 0};

  optical_index_frame_receiver DUT (.*);

  always #5 clk = ~clk;

  task automatic note_failure(input int n, input string msg);
    if (failures < MAX_SHOWN) $display("[%0t] %s", $time, msg);
    failures += n;
  endtask

  function automatic string show(input index_report_t r);
    return $sformatf({"status=%0d long=%0b raw=%h index=%h group=%0d ",
                      "pen_on=%0b leave=%0b ready=%0b"},
                     r.status, r.long_fmt, r.raw, r.index, r.group, r.pen_on, r.pen_leave,
                     r.ready);
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
  function automatic int next_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic post_report(input status_t st, input logic [31:0] raw, input logic [1:0] grp);
    index_report_t r;
    r.status    = st;
    r.long_fmt  = m_long;
    r.raw       = raw;
    r.index     = m_index;
    r.group     = grp;
    r.pen_on    = m_pen_on;
    r.pen_leave = m_pen_leave;
    r.ready     = m_ready;
    report_queue.push_back(r);
  endtask

  task automatic take_index(input logic [15:0] idx, input logic en);
    m_pen_on = 1'b1;
    m_hold   = c_hold;
    m_index  = idx;
    if (en) m_ready = 1'b1;
  endtask

  task automatic classify_frame(input logic en);
    logic [31:0]      w;
    logic [1:0]       grp;
    logic [IDX_W-1:0] idx;
    w = m_shift;
    grp = w[GROUP_LSB+1:GROUP_LSB];
    idx = w[IDX_W-1:0];
    m_in_frame = 1'b0;
    if (m_long) begin
      take_index(w[15:0], en);
      post_report(ST_VALID, w, 2'd0);
    end else if (w == 32'(c_sr)) begin
      post_report(ST_SYS_RESET, w, grp);
    end else if (w == 32'(c_pd)) begin
      m_pen_on = 1'b0;
      m_pen_leave = 1'b1;
      m_hold = '0;
      m_index = '0;
      post_report(ST_POWER_DOWN, w, grp);
    end else if (!w[PRESENT_BIT] || w[NOCODE_BIT]) begin
      m_pen_on = 1'b0;
      m_pen_leave = 1'b1;
      post_report(ST_NO_INDEX, w, grp);
    end else if (idx == c_dc) begin
      post_report(ST_IGNORED, w, grp);
    end else if (idx >= c_lo && idx <= c_hi) begin
      m_pen_on = 1'b0;
      m_pen_leave = 1'b1;
      post_report(ST_NO_INDEX, w, grp);
    end else begin
      take_index(w[15:0], en);
      post_report(ST_VALID, w, grp);
    end
  endtask

  // Applies one accepted input beat to the decoder and queues the result it causes.
  task automatic decode_sensor_beat(input sensor_beat_t b);
    case (b.func)
      FUNC_START: begin
        m_hdr = '0;
        m_shift = '0;
        m_nbits = 0;
        m_long = 1'b0;
        m_in_frame = 1'b1;
      end
      FUNC_TICK: begin
        if (m_hold != 0) begin
          m_hold = m_hold - 1'b1;
          if (m_hold == 0) begin
            m_hold = c_rel;
            m_pen_on = 1'b0;
            m_pen_leave = 1'b1;
            post_report(ST_TIMEOUT, 32'd0, 2'd0);
          end
        end
      end
      FUNC_BIT: begin
        if (m_in_frame) begin
          if (m_nbits < HDR_BITS) begin
            m_hdr = {m_hdr[HDR_BITS-2:0], b.sdio};
            m_nbits++;
            if (m_nbits == HDR_BITS) begin
              if (m_hdr == LONG_HDR) m_long = 1'b1;
              else m_shift = 32'(m_hdr);
            end
          end else if (!m_long) begin
            m_shift = {m_shift[30:0], b.sdio} & SHORT_MASK;
            m_nbits++;
            if (m_nbits >= SHORT_WORD_BITS) classify_frame(b.flag_en);
          end else if (m_nbits < SKIP_END) begin
            m_nbits++;
          end else begin
            m_shift = {m_shift[30:0], b.sdio} & LONG_MASK;
            m_nbits++;
            if (m_nbits >= LONG_END) classify_frame(b.flag_en);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Input side: holds each beat until it is taken, then idles for a random gap.
  always @(posedge clk) begin
    sensor_beat_t b;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        decode_sensor_beat({in_func, in_sdio_bit, in_flag_enable});
        beats_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (beat_queue.size() != 0) begin
          b = beat_queue.pop_front();
          in_valid <= 1'b1;
          in_func <= b.func;
          in_sdio_bit <= b.sdio;
          in_flag_enable <= b.flag_en;
          send_gap = next_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: random stall, each taken beat scored against the oldest prediction.
  always @(posedge clk) begin
    index_report_t got, want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.status    = status_t'(out_status);
        got.long_fmt  = out_long_format;
        got.raw       = out_raw_word;
        got.index     = out_index_value;
        got.group     = out_code_group;
        got.pen_on    = out_pen_on;
        got.pen_leave = out_pen_leave;
        got.ready     = out_index_ready;
        results_seen++;
        if (report_queue.size() == 0) begin
          note_failure(1, $sformatf("result with none predicted: %s", show(got)));
        end else begin
          want = report_queue.pop_front();
          status_hits[int'(want.status)]++;
          if (got.status !== want.status || got.long_fmt !== want.long_fmt ||
              got.raw !== want.raw || got.index !== want.index ||
              got.group !== want.group || got.pen_on !== want.pen_on ||
              got.pen_leave !== want.pen_leave || got.ready !== want.ready)
            note_failure(1, $sformatf("result %0d differs\n  expected %s\n  actual   %s",
                                      results_seen, show(want), show(got)));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = next_gap(recv_calm);
      end
    end
  end

  task automatic queue_beat(input logic [1:0] f, input logic d, input logic en);
    sensor_beat_t b;
    b.func = f;
    b.sdio = d;
    b.flag_en = en;
    beat_queue.push_back(b);
    beats_queued++;
  endtask

  // Shifts out the low n bits of v, MSB first; ticks may be mixed in between bits.
  task automatic queue_bits(input logic [31:0] v, input int n, input int tick_pct,
                            input logic last_en);
    for (int i = n - 1; i >= 0; i--) begin
      if ($urandom_range(0, 99) < tick_pct)
        queue_beat(FUNC_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      queue_beat(FUNC_BIT, v[i], (i == 0) ? last_en : 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic queue_short(input logic [CODE_W-1:0] w, input logic en, input int tick_pct);
    queue_beat(FUNC_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    queue_bits(32'(w), SHORT_WORD_BITS, tick_pct, en);
  endtask

  task automatic queue_long(input logic [31:0] data, input logic en, input int tick_pct);
    queue_beat(FUNC_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    queue_bits(32'(LONG_HDR), HDR_BITS, tick_pct, 1'($urandom_range(0, 1)));
    queue_bits($urandom, LONG_SKIP_BITS, tick_pct, 1'($urandom_range(0, 1)));
    queue_bits(data, LONG_DATA_BITS, tick_pct, en);
  endtask

  task automatic queue_ticks(input int n);
    repeat (n) queue_beat(FUNC_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Steers short words toward the configured codes and the missing-range edges.
  function automatic logic [CODE_W-1:0] pick_short_word();
    logic [CODE_W-1:0] w;
    int sel;
    sel = $urandom_range(0, 99);
    w = {2'b10, 21'($urandom)};
    if (sel < 8) w = c_sr;
    else if (sel < 16) w = c_pd;
    else if (sel < 30) w = 23'($urandom);
    else if (sel < 38) w[IDX_W-1:0] = c_dc;
    else if (sel < 42) w[IDX_W-1:0] = c_lo;
    else if (sel < 46) w[IDX_W-1:0] = c_hi;
    else if (sel < 54 && c_lo <= c_hi) w[IDX_W-1:0] = 18'($urandom_range(c_lo, c_hi));
    return w;
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_WDATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_POWER_DOWN_CODE:   c_pd = val;
      CFG_SYSTEM_RESET_CODE: c_sr = val;
      CFG_DONT_CARE_INDEX:   c_dc = val[IDX_W-1:0];
      CFG_MISSING_MIN:       c_lo = val[IDX_W-1:0];
      CFG_MISSING_MAX:       c_hi = val[IDX_W-1:0];
      CFG_HOLD_MS:           c_hold = val[TIMER_W-1:0];
      CFG_RELEASE_MS:        c_rel = val[TIMER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic [CODE_W-1:0] pd, sr, input logic [IDX_W-1:0] dc, lo,
                              hi, input logic [TIMER_W-1:0] hold, rel);
    write_reg(CFG_POWER_DOWN_CODE, pd);
    write_reg(CFG_SYSTEM_RESET_CODE, sr);
    write_reg(CFG_DONT_CARE_INDEX, CFG_WDATA_W'(dc));
    write_reg(CFG_MISSING_MIN, CFG_WDATA_W'(lo));
    write_reg(CFG_MISSING_MAX, CFG_WDATA_W'(hi));
    write_reg(CFG_HOLD_MS, CFG_WDATA_W'(hold));
    write_reg(CFG_RELEASE_MS, CFG_WDATA_W'(rel));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_loaded++;
  endtask

  // Lets the sender run dry, then waits for every predicted result to come back.
  task automatic wait_idle();
    int waited;
    waited = 0;
    while (beat_queue.size() != 0 || in_valid) @(negedge clk);
    while (report_queue.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (report_queue.size() != 0) begin
      note_failure(report_queue.size(),
                   $sformatf("%0d predicted results never arrived", report_queue.size()));
      report_queue.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [IDX_W-1:0] lo;
    int sel, tick_pct, phase_end;

    m_hdr = '0;
    m_shift = '0;
    m_nbits = 0;
    m_long = 1'b0;
    m_in_frame = 1'b0;
    m_hold = '0;
    m_index = '0;
    m_pen_on = 1'b0;
    m_pen_leave = 1'b1;
    m_ready = 1'b0;
    c_pd = '0;
    c_sr = '0;
    c_dc = '0;
    c_lo = '0;
    c_hi = '0;
    c_hold = 16'd1000;
    c_rel = 16'd100;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: stray bits, the unused event code and an idle tick do nothing;
    // an all-zero word matches the system reset code.
    queue_beat(FUNC_BIT, 1'b1, 1'b1);
    queue_beat(FUNC_BIT, 1'b0, 1'b0);
    queue_beat(FUNC_UNUSED, 1'b1, 1'b1);
    queue_beat(FUNC_TICK, 1'b0, 1'b0);
    queue_short('0, 1'b1, 0);
    wait_idle();

    load_setting(23'h7FFFFF, 23'h412345, 18'h3FFFF, 18'h00010, 18'h00020, 16'd3, 16'd2);
    queue_short(23'h412345, 1'b0, 0);   // system reset
    queue_short(23'h7FFFFF, 1'b0, 0);   // power down wins over the no-code bit
    queue_short(23'h012345, 1'b1, 0);   // present bit clear
    queue_short(23'h6D1234, 1'b1, 0);   // no-code bit set
    queue_short(23'h43FFFF, 1'b1, 0);   // don't-care index
    queue_short(23'h400015, 1'b1, 0);   // inside the missing range
    queue_short(23'h4ABCDE, 1'b0, 0);   // valid, ready flag stays low
    queue_ticks(5);
    queue_long(32'hFFFFFFFF, 1'b1, 0);
    queue_long(32'h00000000, 1'b0, 0);
    queue_beat(FUNC_START, 1'b0, 1'b0);
    queue_bits($urandom, 10, 0, 1'b0);  // abandoned by the restart below
    queue_short(23'h5FFFF0, 1'b1, 0);
    queue_long($urandom, 1'b1, 30);     // timeouts while a long frame is in flight
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        // Empty missing range, shortest timers.
        load_setting('0, 23'h7FFFFF, '0, 18'h3FFFF, '0, 16'd1, 16'd1);
      end else if (p == 1) begin
        // Missing range covers every index, longest timers.
        load_setting(23'h7FFFFF, '0, 18'h3FFFF, '0, 18'h3FFFF, 16'hFFFF, 16'hFFFF);
      end else begin
        lo = 18'($urandom);
        load_setting(($urandom_range(0, 1) != 0) ? {2'b10, 21'($urandom)} : 23'($urandom),
                     ($urandom_range(0, 1) != 0) ? {2'b10, 21'($urandom)} : 23'($urandom),
                     18'($urandom), lo, lo + 18'($urandom_range(0, 3000)),
                     16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)));
      end
      tick_pct = $urandom_range(0, 15);
      phase_end = beats_queued + PHASE_BEATS;
      while (beats_queued < phase_end) begin
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
          queue_short(pick_short_word(), 1'($urandom_range(0, 1)), tick_pct);
        end else if (sel < 65) begin
          queue_long($urandom, 1'($urandom_range(0, 1)), tick_pct);
        end else if (sel < 80) begin
          queue_ticks($urandom_range(1, 8));
        end else if (sel < 92) begin
          queue_beat(FUNC_START, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          queue_bits($urandom, $urandom_range(0, 40), tick_pct, 1'($urandom_range(0, 1)));
        end else begin
          repeat ($urandom_range(1, 5))
            queue_beat(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        end
      end
      // Close any half-received frame before the registers change.
      queue_short(pick_short_word(), 1'($urandom_range(0, 1)), 0);
      wait_idle();
    end

    $display("Run covered %0d input beats and %0d result beats over %0d register settings.",
             beats_taken, results_seen, settings_loaded);
    $display({"By status: valid %0d, no index %0d, ignored %0d, power down %0d, ",
              "reset %0d, timeout %0d."},
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4],
             status_hits[5]);
    if (failures == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
src/oifr_pkg.sv
src/oifr_classify.sv
src/optical_index_frame_receiver.sv
src/oifr_checker.sv
tb/optical_index_frame_receiver_tb.sv
